// File: hdl/opp_pkg.sv
// ----------------------------------------------------------------------------
// opp_pkg
// Shared widths, register indexes and datapath control types of the
// onset peak picker.
// ----------------------------------------------------------------------------
package opp_pkg;

    localparam int STRENGTH_W = 16;
    localparam int OFFSET_W   = 18;
    localparam int GAIN_W     = 16;
    localparam int HALF_W     = 5;
    localparam int POS_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;
    localparam int DIFF_W     = OFFSET_W + 1;  // strength minus offset
    localparam int FRAC_W     = 12;            // gain fraction bits

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MHALF  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PHALF  = 2'd3;

    localparam logic signed [OFFSET_W-1:0] OFFSET_RESET = '0;
    localparam logic [GAIN_W-1:0]          GAIN_RESET   = 16'd4096;
    localparam logic [HALF_W-1:0]          HALF_RESET   = 5'd2;

    localparam logic [POS_W-1:0] POS_MAX = '1;

    // sequencer to datapath
    typedef struct packed {
        logic start;      // clear accumulator, arm peak flag
        logic cur_load;   // read data is the value under decision
        logic acc_add;    // accumulate one window entry
        logic use_first;  // substitute first value / skip entry
        logic mul_gain;   // gain * window sum
        logic mul_span;   // (value - offset) * span
        logic cmp_thr;    // threshold compare
        logic peak_chk;   // neighbour compare
    } t_dp_ctrl;

    typedef struct packed {
        logic above;
        logic peak;
    } t_dp_stat;

endpackage

// File: hdl/opp_ram.sv
// ----------------------------------------------------------------------------
// opp_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module opp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/opp_dp.sv
// ----------------------------------------------------------------------------
// opp_dp
// Shared datapath: window accumulator, one multiplier used twice per
// decision, and one signed comparator for threshold and neighbour tests.
// ----------------------------------------------------------------------------
module opp_dp #(
    parameter int SUM_W  = 22,
    parameter int SPAN_W = 6
) (
    input  logic                                 i_clk,
    input  opp_pkg::t_dp_ctrl                    i_ctrl,
    input  logic [opp_pkg::STRENGTH_W-1:0]       i_rdata,
    input  logic [opp_pkg::STRENGTH_W-1:0]       i_first,
    input  logic signed [opp_pkg::OFFSET_W-1:0]  i_offset,
    input  logic [opp_pkg::GAIN_W-1:0]           i_gain,
    input  logic [SPAN_W-1:0]                    i_span,
    output opp_pkg::t_dp_stat                    o_stat
);
    import opp_pkg::*;

    localparam int XW = ((SUM_W > DIFF_W) ? SUM_W : DIFF_W) + 1;
    localparam int YW = ((GAIN_W > SPAN_W) ? GAIN_W : SPAN_W) + 1;
    localparam int PW = XW + YW;
    localparam int CW = PW + FRAC_W;

    logic [STRENGTH_W-1:0]    r_cur;
    logic [SUM_W-1:0]         r_acc;
    logic signed [PW-1:0]     r_pa;   // gain * sum
    logic signed [PW-1:0]     r_pb;   // (value - offset) * span
    logic                     r_above;
    logic                     r_peak;

    logic [STRENGTH_W-1:0]    add_opd;
    logic signed [DIFF_W-1:0] diff;
    logic signed [XW-1:0]     mul_x;
    logic signed [YW-1:0]     mul_y;
    logic signed [PW-1:0]     prod;
    logic signed [CW-1:0]     cmp_a;
    logic signed [CW-1:0]     cmp_b;
    logic                     gt;

    assign add_opd = i_ctrl.use_first ? i_first : i_rdata;
    assign diff    = $signed({{(DIFF_W-STRENGTH_W){1'b0}}, r_cur})
                   - $signed({i_offset[OFFSET_W-1], i_offset});

    always_comb begin
        if (i_ctrl.mul_gain) begin
            mul_x = XW'({1'b0, r_acc});
            mul_y = YW'({1'b0, i_gain});
        end else begin
            mul_x = XW'(diff);
            mul_y = YW'({1'b0, i_span});
        end
    end

    assign prod = mul_x * mul_y;

    // threshold: value*span*4096 > offset*span*4096 + gain*sum
    always_comb begin
        if (i_ctrl.cmp_thr) begin
            cmp_a = {r_pb, {FRAC_W{1'b0}}};
            cmp_b = CW'(r_pa);
        end else begin
            cmp_a = CW'({1'b0, i_rdata});
            cmp_b = CW'({1'b0, r_cur});
        end
    end

    assign gt = cmp_a > cmp_b;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.cur_load) begin
            r_cur <= i_rdata;
        end
        if (i_ctrl.start) begin
            r_acc  <= '0;
            r_peak <= 1'b1;
        end else begin
            if (i_ctrl.acc_add) begin
                r_acc <= r_acc + SUM_W'(add_opd);
            end
            if (i_ctrl.peak_chk && gt) begin
                r_peak <= 1'b0;
            end
        end
        if (i_ctrl.mul_gain) begin
            r_pa <= prod;
        end
        if (i_ctrl.mul_span) begin
            r_pb <= prod;
        end
        if (i_ctrl.cmp_thr) begin
            r_above <= gt;
        end
    end

    assign o_stat.above = r_above;
    assign o_stat.peak  = r_peak;

endmodule

// File: hdl/onset_peak_picker.sv
// ----------------------------------------------------------------------------
// onset_peak_picker
// Adaptive-threshold peak picking over a stream of onset-strength values.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (i_in_valid / o_in_stall) takes one strength value per
//   transaction; i_final_value marks the last value of a sequence. Output
//   channel (o_out_valid / i_out_stall) returns one decision per position,
//   in position order, with o_final_result on the last one of a sequence.
//   A position is decided once max(M,P) later values are in, or when the
//   final value arrives, which flushes every open position.
//   Timing: the block takes one value, then stalls input while it works.
//   Each decision picks the oldest open position, sums its window (one
//   history RAM read per entry), forms the two products on the shared
//   multiplier and does the compare, scans the neighbours (skipped if
//   below threshold) and emits.
//   Receiver stall: a decision waits in the emit step until the output
//   register is free; input is accepted while a finished result waits.
//   Reset (synchronous, active low) clears counters, handshake state and
//   registers to their reset values; history RAM contents are not cleared.
// ----------------------------------------------------------------------------
module onset_peak_picker #(
    parameter int MAX_HALF_WINDOW = 16,
    parameter int HISTORY_DEPTH   = 64
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                i_cfg_we,
    input  logic [opp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [opp_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // input channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [opp_pkg::STRENGTH_W-1:0]      i_strength,
    input  logic                                i_final_value,
    // output channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic                                o_onset,
    output logic [opp_pkg::POS_W-1:0]           o_position,
    output logic                                o_final_result
);
    import opp_pkg::*;

    localparam int DEPTH_HALF = (HISTORY_DEPTH - 1) / 2;
    localparam int WIN_CAP    = (MAX_HALF_WINDOW < DEPTH_HALF) ? MAX_HALF_WINDOW
                                                               : DEPTH_HALF;
    localparam int AW     = $clog2(HISTORY_DEPTH);
    localparam int RW     = AW + 2;                  // signed ring arithmetic
    localparam int OW     = $clog2(WIN_CAP + 2);     // open position count
    localparam int KW     = OW + 1;                  // signed window offset
    localparam int MW     = (HALF_W > $clog2(WIN_CAP + 1)) ? HALF_W
                                                           : $clog2(WIN_CAP + 1);
    localparam int DW     = (MW > OW) ? MW : OW;
    localparam int SPAN_W = $clog2(2 * WIN_CAP + 2);
    localparam int SUM_W  = STRENGTH_W + SPAN_W;
    localparam int DKW    = POS_W + 2;

    localparam logic signed [RW-1:0] HD_S = RW'(HISTORY_DEPTH);

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_SUM   = 3'd2;
    localparam logic [2:0] S_MUL1  = 3'd3;
    localparam logic [2:0] S_MUL2  = 3'd4;
    localparam logic [2:0] S_CMP   = 3'd5;
    localparam logic [2:0] S_PEAK  = 3'd6;
    localparam logic [2:0] S_EMIT  = 3'd7;

    logic [2:0]                   r_state;
    logic [2:0]                   n_state;

    // configuration registers
    logic signed [OFFSET_W-1:0]   r_offset;
    logic [GAIN_W-1:0]            r_gain;
    logic [HALF_W-1:0]            r_mhw;
    logic [HALF_W-1:0]            r_phw;

    // sequence state
    logic [STRENGTH_W-1:0]        r_first;
    logic [POS_W-1:0]             r_recv;
    logic [POS_W-1:0]             r_dec;
    logic [OW-1:0]                r_open;
    logic [AW-1:0]                r_wr;
    logic                         r_fin;

    // window walk
    logic signed [KW-1:0]         r_k;
    logic                         r_pend;
    logic                         r_cur_pend;
    logic                         r_sub;

    // output register
    logic                         r_out_valid;
    logic                         r_out_onset;
    logic [POS_W-1:0]             r_out_pos;
    logic                         r_out_fin;

    logic [MW-1:0]                mhw_ext;
    logic [MW-1:0]                phw_ext;
    logic [MW-1:0]                m_cap;
    logic [MW-1:0]                p_cap;
    logic [MW-1:0]                dly;
    logic signed [KW-1:0]         m_s;
    logic signed [KW-1:0]         p_s;
    logic [SPAN_W-1:0]            span;
    logic                         in_acc;
    logic                         out_free;
    logic                         decide;
    logic signed [KW-1:0]         k_sel;
    logic signed [RW-1:0]         raw;
    logic signed [RW-1:0]         ring;
    logic [AW-1:0]                rd_addr;
    logic signed [DKW-1:0]        dk;
    logic                         beyond;
    logic                         sub_sum;
    logic                         sub_peak;
    logic [STRENGTH_W-1:0]        rdata;
    t_dp_ctrl                     dp_ctrl;
    t_dp_stat                     dp_stat;

    // window sizes saturate at what the history ring can hold
    assign mhw_ext = MW'(r_mhw);
    assign phw_ext = MW'(r_phw);
    assign m_cap   = (mhw_ext > MW'(WIN_CAP)) ? MW'(WIN_CAP) : mhw_ext;
    assign p_cap   = (phw_ext > MW'(WIN_CAP)) ? MW'(WIN_CAP) : phw_ext;
    assign dly     = (m_cap > p_cap) ? m_cap : p_cap;
    assign m_s     = KW'(m_cap);
    assign p_s     = KW'(p_cap);
    assign span    = SPAN_W'({m_cap, 1'b1});

    assign in_acc   = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_out_stall;
    // oldest open position is ready once enough later values are in, or the final value is in
    assign decide   = (r_open != '0) && (r_fin || (DW'(r_open) > DW'(dly)));

    // ring slot of the oldest open position plus offset k
    assign k_sel = (r_state == S_CHECK) ? '0 : r_k;
    assign raw   = RW'({1'b0, r_wr}) - RW'({1'b0, r_open}) + RW'(k_sel);

    always_comb begin
        if (raw < 0) begin
            ring = raw + HD_S;
        end else if (raw >= HD_S) begin
            ring = raw - HD_S;
        end else begin
            ring = raw;
        end
    end

    assign rd_addr = ring[AW-1:0];

    // window edges: before the sequence, and past the newest value
    assign dk       = DKW'({1'b0, r_dec}) + DKW'(r_k);
    assign beyond   = r_k >= $signed({1'b0, r_open});
    assign sub_sum  = (dk <= 0) || beyond;
    assign sub_peak = dk[DKW-1] || beyond;

    opp_ram #(
        .WIDTH (STRENGTH_W),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_wr),
        .i_wdata (i_strength),
        .i_raddr (rd_addr),
        .o_rdata (rdata)
    );

    always_comb begin
        dp_ctrl           = '0;
        dp_ctrl.start     = (r_state == S_CHECK) && decide;
        dp_ctrl.cur_load  = r_cur_pend;
        dp_ctrl.acc_add   = r_pend && (r_state == S_SUM);
        dp_ctrl.use_first = r_sub;
        dp_ctrl.mul_gain  = (r_state == S_MUL1);
        dp_ctrl.mul_span  = (r_state == S_MUL2);
        dp_ctrl.cmp_thr   = (r_state == S_CMP);
        dp_ctrl.peak_chk  = r_pend && (r_state == S_PEAK) && !r_sub;
    end

    opp_dp #(
        .SUM_W  (SUM_W),
        .SPAN_W (SPAN_W)
    ) u_dp (
        .i_clk    (i_clk),
        .i_ctrl   (dp_ctrl),
        .i_rdata  (rdata),
        .i_first  (r_first),
        .i_offset (r_offset),
        .i_gain   (r_gain),
        .i_span   (span),
        .o_stat   (dp_stat)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_CHECK;
            end
            S_CHECK: begin
                n_state = decide ? S_SUM : S_IDLE;
            end
            S_SUM: begin
                if (r_k > m_s) n_state = S_MUL1;
            end
            S_MUL1: n_state = S_MUL2;
            S_MUL2: n_state = S_CMP;
            S_CMP:  n_state = S_PEAK;
            S_PEAK: begin
                // below threshold: no neighbour scan
                if (!dp_stat.above || (r_k > p_s)) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) n_state = S_CHECK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_offset    <= OFFSET_RESET;
            r_gain      <= GAIN_RESET;
            r_mhw       <= HALF_RESET;
            r_phw       <= HALF_RESET;
            r_first     <= '0;
            r_recv      <= '0;
            r_dec       <= '0;
            r_open      <= '0;
            r_wr        <= '0;
            r_fin       <= 1'b0;
            r_k         <= '0;
            r_pend      <= 1'b0;
            r_cur_pend  <= 1'b0;
            r_sub       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            // read data of this cycle's window entry arrives next cycle
            r_pend     <= ((r_state == S_SUM) && (r_k <= m_s)) ||
                          ((r_state == S_PEAK) && dp_stat.above && (r_k <= p_s));
            r_cur_pend <= (r_state == S_CHECK) && decide;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_OFFSET: r_offset <= $signed(i_cfg_data[OFFSET_W-1:0]);
                    CFG_GAIN:   r_gain   <= i_cfg_data[GAIN_W-1:0];
                    CFG_MHALF:  r_mhw    <= i_cfg_data[HALF_W-1:0];
                    CFG_PHALF:  r_phw    <= i_cfg_data[HALF_W-1:0];
                endcase
            end

            if ((r_state == S_EMIT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (r_recv == '0) r_first <= i_strength;
                        r_wr   <= (r_wr == AW'(HISTORY_DEPTH - 1)) ? '0 : r_wr + AW'(1);
                        r_open <= r_open + OW'(1);
                        if (r_recv != POS_MAX) r_recv <= r_recv + POS_W'(1);
                        r_fin  <= i_final_value;
                    end
                end
                S_CHECK: begin
                    if (decide) begin
                        r_k <= -m_s;
                    end else if (r_fin) begin
                        // sequence flushed: next value starts at position 0
                        r_recv  <= '0;
                        r_dec   <= '0;
                        r_open  <= '0;
                        r_first <= '0;
                    end
                end
                S_SUM: begin
                    if (r_k <= m_s) begin
                        r_sub <= sub_sum;
                        r_k   <= r_k + KW'(1);
                    end
                end
                S_MUL1, S_MUL2: begin
                end
                S_CMP: begin
                    r_k <= -p_s;
                end
                S_PEAK: begin
                    if (dp_stat.above && (r_k <= p_s)) begin
                        r_sub <= sub_peak;
                        r_k   <= r_k + KW'(1);
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_open <= r_open - OW'(1);
                        if (r_dec != POS_MAX) r_dec <= r_dec + POS_W'(1);
                    end
                end
            endcase
        end
    end

    // output payload, loaded with the valid flag
    always_ff @(posedge i_clk) begin
        if ((r_state == S_EMIT) && out_free) begin
            r_out_onset <= dp_stat.above && dp_stat.peak;
            r_out_pos   <= r_dec;
            r_out_fin   <= r_fin && (r_open == OW'(1));
        end
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_onset        = r_out_onset;
    assign o_position     = r_out_pos;
    assign o_final_result = r_out_fin;

endmodule

// File: hdl/opp_chk.sv
// ----------------------------------------------------------------------------
// opp_chk
// Port-level checks of the onset peak picker, bound to the top level.
// ----------------------------------------------------------------------------
module opp_chk (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          o_in_stall,
    input  logic                          o_out_valid,
    input  logic                          i_out_stall,
    input  logic                          o_onset,
    input  logic [opp_pkg::POS_W-1:0]     o_position,
    input  logic                          o_final_result
);
    import opp_pkg::*;

    // an accepted transaction always occupies the sequencer
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input not stalled after accepted transaction");

    // the block only goes busy because of a transaction
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_stall) |-> $past(i_in_valid))
        else $error("input stall rose without a transaction");

    // results are only produced while a value is being worked on
    a_result_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_stall)
        else $error("result appeared while idle");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable({o_onset, o_position, o_final_result})))
        else $error("stalled result changed");

endmodule

bind onset_peak_picker opp_chk u_opp_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_onset        (o_onset),
    .o_position     (o_position),
    .o_final_result (o_final_result)
);

// File: test/opp_decision_checker.sv
// ----------------------------------------------------------------------------
// Onset peak picker decision checker
// Watches the configuration port and both channels of the peak picker. It keeps
// its own model of the picker state, predicts the decisions that each accepted
// strength value releases, and compares every returned decision with the
// oldest prediction still waiting.
// ----------------------------------------------------------------------------
module opp_decision_checker #(
    parameter int MAX_HALF_WINDOW = 16,
    parameter int HISTORY_DEPTH   = 64
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [opp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [opp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  logic [opp_pkg::STRENGTH_W-1:0] i_strength,
    input  logic                           i_final_value,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  logic                           i_onset,
    input  logic [opp_pkg::POS_W-1:0]      i_position,
    input  logic                           i_final_result,
    output int                             o_mismatches,
    output int                             o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import opp_pkg::*;

    localparam int DEPTH_HALF = (HISTORY_DEPTH - 1) / 2;
    localparam int WIN_CAP    = (MAX_HALF_WINDOW < DEPTH_HALF) ? MAX_HALF_WINDOW : DEPTH_HALF;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic             onset;
        logic [POS_W-1:0] position;
        logic             final_result;
    } t_decision;

    logic signed [OFFSET_W-1:0] thr_offset;
    logic [GAIN_W-1:0]          thr_gain;
    logic [HALF_W-1:0]          mean_half;
    logic [HALF_W-1:0]          peak_half;

    logic [STRENGTH_W-1:0] strength_ring [HISTORY_DEPTH];
    logic [STRENGTH_W-1:0] seq_first;
    int unsigned           seen_count;
    int unsigned           decided_count;
    int unsigned           open_count;
    int unsigned           ring_wr;

    t_decision decision_q [$];
    t_decision got;
    t_decision want;
    int        mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    function automatic int unsigned clamp_half(logic [HALF_W-1:0] w);
        return (int'(w) > WIN_CAP) ? WIN_CAP : int'(w);
    endfunction

    function automatic logic [STRENGTH_W-1:0] ring_value(int unsigned base, int k);
        return strength_ring[(int'(base) + HISTORY_DEPTH + k) % HISTORY_DEPTH];
    endfunction

    // Decision for the oldest open position: above the adaptive threshold and
    // not below any neighbour that exists.
    function automatic logic oldest_is_onset();
        int unsigned           mh;
        int unsigned           ph;
        int unsigned           base;
        int                    reach;
        int                    d;
        int                    k;
        logic [STRENGTH_W-1:0] cur;
        longint                win_sum;
        longint                span;
        longint                lhs;
        longint                rhs;

        mh      = clamp_half(mean_half);
        ph      = clamp_half(peak_half);
        base    = (ring_wr + HISTORY_DEPTH - open_count) % HISTORY_DEPTH;
        reach   = int'(open_count) - 1;
        d       = int'(decided_count);
        cur     = strength_ring[base];
        win_sum = 0;

        // position 0, before the start and past the end all count as the first value
        for (k = -int'(mh); k <= int'(mh); k++) begin
            if (d + k <= 0 || k > reach)
                win_sum += longint'(seq_first);
            else
                win_sum += longint'(ring_value(base, k));
        end
        span = 4096 * longint'(2 * mh + 1);
        lhs  = longint'(cur) * span;
        rhs  = longint'(thr_offset) * span + longint'(thr_gain) * win_sum;
        if (lhs <= rhs)
            return 1'b0;

        for (k = -int'(ph); k <= int'(ph); k++) begin
            if (d + k < 0 || k > reach)
                continue;
            if (cur < ring_value(base, k))
                return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic predict_decisions(logic [STRENGTH_W-1:0] s, logic is_last);
        int unsigned mh;
        int unsigned ph;
        int unsigned lag;
        t_decision   dec;

        mh  = clamp_half(mean_half);
        ph  = clamp_half(peak_half);
        lag = (mh > ph) ? mh : ph;

        if (seen_count == 0)
            seq_first = s;
        strength_ring[ring_wr] = s;
        ring_wr = (ring_wr + 1) % HISTORY_DEPTH;
        open_count++;
        if (seen_count < POS_MAX)
            seen_count++;

        // a lowered lag or the last value may release several positions at once
        while (open_count > 0 && (is_last || open_count - 1 >= lag)) begin
            dec.onset        = oldest_is_onset();
            dec.position     = decided_count[POS_W-1:0];
            dec.final_result = is_last && open_count == 1;
            decision_q.insert(decision_q.size(), dec);
            open_count--;
            if (decided_count < POS_MAX)
                decided_count++;
        end

        if (is_last) begin
            seen_count    = 0;
            decided_count = 0;
            open_count    = 0;
            seq_first     = '0;
        end
    endtask

    task automatic note_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display("%0t ns: %s: expected %s, got onset=%0b position=%0d final=%0b",
                     $realtime, "decision mismatch", what, got.onset, got.position,
                     got.final_result);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            thr_offset    = OFFSET_RESET;
            thr_gain      = GAIN_RESET;
            mean_half     = HALF_RESET;
            peak_half     = HALF_RESET;
            seq_first     = '0;
            seen_count    = 0;
            decided_count = 0;
            open_count    = 0;
            ring_wr       = 0;
            decision_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_OFFSET: thr_offset = i_cfg_data[OFFSET_W-1:0];
                    CFG_GAIN:   thr_gain   = i_cfg_data[GAIN_W-1:0];
                    CFG_MHALF:  mean_half  = i_cfg_data[HALF_W-1:0];
                    CFG_PHALF:  peak_half  = i_cfg_data[HALF_W-1:0];
                    default: ;
                endcase
            end

            // results are registered, so compare before adding this edge's predictions
            if (i_out_valid && !i_out_stall) begin
                got = {i_onset, i_position, i_final_result};
                if (decision_q.size() == 0) begin
                    note_mismatch("no decision");
                end else begin
                    want = decision_q.pop_front();
                    if (got.onset !== want.onset || got.position !== want.position ||
                        got.final_result !== want.final_result)
                        note_mismatch($sformatf("onset=%0b position=%0d final=%0b",
                                                want.onset, want.position,
                                                want.final_result));
                end
            end

            if (i_in_valid && !i_in_stall)
                predict_decisions(i_strength, i_final_value);
        end
        o_outstanding <= decision_q.size();
    end

endmodule

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// Onset peak picker testbench
// Drives strength sequences into the peak picker under several register
// settings and traffic patterns: a short directed part, then random phases.
// A separate checker predicts and compares every decision; this module gives
// the verdict.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import opp_pkg::*;

    // traffic pattern of a phase
    typedef enum int {
        TRAFFIC_STEADY,
        TRAFFIC_SEND_GAPS,
        TRAFFIC_RECV_STALLS,
        TRAFFIC_BOTH
    } t_traffic;

    localparam int BUSY_PCT       = 77;
    localparam int BOTH_PCT       = 15;
    localparam int SETTLE_CYCLES  = 16;     // covers a step that decides nothing
    localparam int TAIL_CYCLES    = 200;
    localparam int WATCHDOG_LIMIT = 5000;   // exceeds the longest decision
    localparam int RANDOM_PHASES  = 12;
    localparam int PHASE_ITEMS    = 34;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  i_in_valid    = 1'b0;
    logic [STRENGTH_W-1:0] i_strength    = '0;
    logic                  i_final_value = 1'b0;
    logic                  i_out_stall   = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic                  o_onset;
    logic [POS_W-1:0]      o_position;
    logic                  o_final_result;

    int                    send_gap_pct   = 0;
    int                    recv_stall_pct = 0;
    int                    quiet_cycles   = 0;
    int                    seq_left       = 0;
    int                    mismatches;
    int                    outstanding;
    logic [STRENGTH_W-1:0] last_strength  = '0;

    onset_peak_picker u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_strength     (i_strength),
        .i_final_value  (i_final_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_onset        (o_onset),
        .o_position     (o_position),
        .o_final_result (o_final_result)
    );

    opp_decision_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_strength     (i_strength),
        .i_final_value  (i_final_value),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_onset        (o_onset),
        .i_position     (o_position),
        .i_final_result (o_final_result),
        .o_mismatches   (mismatches),
        .o_outstanding  (outstanding)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Receiver back-pressure, redrawn every cycle; zero percent means never.
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog: cycles in which nothing at all moves on any port.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_in_valid && !o_in_stall) ||
            (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin : watchdog
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic set_traffic(t_traffic mode);
        case (mode)
            TRAFFIC_STEADY:      begin send_gap_pct = 0;        recv_stall_pct = 0;        end
            TRAFFIC_SEND_GAPS:   begin send_gap_pct = BUSY_PCT; recv_stall_pct = 0;        end
            TRAFFIC_RECV_STALLS: begin send_gap_pct = 0;        recv_stall_pct = BUSY_PCT; end
            default:             begin send_gap_pct = BOTH_PCT; recv_stall_pct = BOTH_PCT; end
        endcase
    endtask

    // Mix of extremes, repeats (plateaus for the neighbour test), small and
    // full-range values.
    function automatic logic [STRENGTH_W-1:0] pick_strength();
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return last_strength;
            3:       return STRENGTH_W'($urandom_range(1023));
            default: return STRENGTH_W'($urandom_range(16'hFFFF));
        endcase
    endfunction

    // One input transaction. Optional idle cycles first, with junk payload
    // while valid is low; valid is only lowered when a gap is actually taken.
    task automatic send_value(logic [STRENGTH_W-1:0] value, logic is_last);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid    <= 1'b0;
            i_strength    <= STRENGTH_W'($urandom_range(16'hFFFF));
            i_final_value <= 1'($urandom_range(1));
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_strength    <= value;
        i_final_value <= is_last;
        last_strength  = value;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Hold input until every predicted decision is back, then give the block
    // time to finish any step that releases nothing.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // All four registers, back to back, once the block is quiet.
    task automatic apply_setting(int offset, int gain, int m_half, int p_half);
        wait_for_drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_OFFSET;
        i_cfg_data  <= offset[OFFSET_W-1:0];
        @(posedge i_clk);
        i_cfg_index <= CFG_GAIN;
        i_cfg_data  <= CFG_DATA_W'(gain[GAIN_W-1:0]);
        @(posedge i_clk);
        i_cfg_index <= CFG_MHALF;
        i_cfg_data  <= CFG_DATA_W'(m_half[HALF_W-1:0]);
        @(posedge i_clk);
        i_cfg_index <= CFG_PHALF;
        i_cfg_data  <= CFG_DATA_W'(p_half[HALF_W-1:0]);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin : stimulus
        logic [STRENGTH_W-1:0] plateau_run [7] = '{16'h0000, 16'hFFFF, 16'hFFFF, 16'h0001,
                                                   16'h0000, 16'h8000, 16'h8000};
        logic [STRENGTH_W-1:0] open_run [5]    = '{16'd100, 16'd5000, 16'd300, 16'd7000,
                                                   16'd200};
        int m_half;
        int p_half;

        set_traffic(TRAFFIC_STEADY);
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Register reset values. A sequence of one value, then a short one with
        // both strength extremes, equal neighbours and the left-edge substitution;
        // its last value flushes the open tail.
        send_value(16'hFFFF, 1'b1);
        foreach (plateau_run[i])
            send_value(plateau_run[i], i == 6);

        // Wide windows hold five values open with nothing decided; narrowing
        // them mid-sequence must release the backlog on the next transaction.
        apply_setting(0, 4096, 8, 8);
        foreach (open_run[i])
            send_value(open_run[i], 1'b0);
        apply_setting(-3277, 6144, 1, 1);
        send_value(16'd9000, 1'b0);
        send_value(16'd50, 1'b0);
        send_value(16'd60000, 1'b1);

        // Half windows beyond the cap saturate.
        apply_setting(0, 4096, 31, 20);
        repeat (5) send_value(pick_strength(), 1'b0);
        send_value(pick_strength(), 1'b1);

        // Random phases. Sequences run across phase boundaries, so settings
        // also change with positions still open.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph)
                0: apply_setting(-131072, 65535, 0, 0);
                1: apply_setting(131071, 0, 16, 16);
                2: apply_setting(0, 4096, 31, 1);
                3: apply_setting(-1, 16384, 1, 31);
                default: begin
                    m_half = ($urandom_range(7) == 0) ? int'($urandom_range(31))
                                                      : int'($urandom_range(4));
                    p_half = ($urandom_range(7) == 0) ? int'($urandom_range(31))
                                                      : int'($urandom_range(4));
                    apply_setting(int'($urandom_range(16384)) - 8192,
                                  int'($urandom_range(12288)), m_half, p_half);
                end
            endcase
            set_traffic(t_traffic'(ph % 4));
            repeat (PHASE_ITEMS) begin
                if (seq_left == 0)
                    seq_left = ($urandom_range(9) == 0) ? int'($urandom_range(3, 1))
                                                        : int'($urandom_range(40, 4));
                seq_left--;
                send_value(pick_strength(), seq_left == 0);
            end
        end

        // close whatever sequence is still open
        send_value(pick_strength(), 1'b1);

        wait_for_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// File: files.f
hdl/opp_pkg.sv
hdl/opp_ram.sv
hdl/opp_dp.sv
hdl/onset_peak_picker.sv
hdl/opp_chk.sv
test/opp_decision_checker.sv
test/testbench.sv
